>>> sv/kabf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kabf_pkg;

   // Formats: angle and rate Q16.16, dt Q0.24, noise Q0.32, covariance Q8.32, gains Q1.23.
   localparam int AngleWidth = 32;
   localparam int DtWidth    = 24;
   localparam int NoiseWidth = 32;
   localparam int CovWidth   = 40;
   localparam int GainWidth  = 24;
   localparam int GainFrac   = 23;
   localparam int DtFrac     = 24;
   localparam int StepWidth  = 6;
   localparam int CsrIdxWidth = 2;

   localparam logic [NoiseWidth-1:0] QA_RESET = 32'd4294967;
   localparam logic [NoiseWidth-1:0] QB_RESET = 32'd12884902;
   localparam logic [NoiseWidth-1:0] R_RESET  = 32'd128849019;

   localparam logic [CsrIdxWidth-1:0] REG_QA = 2'd0;
   localparam logic [CsrIdxWidth-1:0] REG_QB = 2'd1;
   localparam logic [CsrIdxWidth-1:0] REG_R  = 2'd2;

   localparam logic [1:0] P00 = 2'd0;
   localparam logic [1:0] P01 = 2'd1;
   localparam logic [1:0] P10 = 2'd2;
   localparam logic [1:0] P11 = 2'd3;

   localparam logic signed [GainWidth-1:0] GAIN_MAX = 24'sh7FFFFF;
   localparam logic signed [GainWidth-1:0] GAIN_MIN = -24'sh800000;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_RATE,
      OP_MUL,
      OP_ANGLE_PRED,
      OP_DP11,
      OP_T,
      OP_P00_PRED,
      OP_P01_PRED,
      OP_P10_PRED,
      OP_P11_PRED,
      OP_S,
      OP_Y,
      OP_DIV_K0,
      OP_DIV_K1,
      OP_K0,
      OP_K1,
      OP_ANGLE_CORR,
      OP_BIAS_CORR,
      OP_P00_CORR,
      OP_P01_CORR,
      OP_P10_CORR,
      OP_P11_CORR,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      MA_DT,
      MA_K0,
      MA_K1
   } mula_type;

   typedef enum logic [2:0] {
      MB_RATE,
      MB_P11,
      MB_T,
      MB_QB,
      MB_Y,
      MB_P00,
      MB_P01
   } mulb_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_REQ,
      BR_DIV,
      BR_END,
      BR_HOME
   } branch_type;

   typedef struct packed {
      op_type     op;
      mula_type   ma;
      mulb_type   mb;
      branch_type br;
   } ctrl_type;

   // The microprogram: one control word per step.
   function automatic ctrl_type rom_word(input logic [StepWidth-1:0] step);
      ctrl_type w;
      w = '{op: OP_NOP, ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
      case (step)
         6'd0:  w = '{op: OP_LOAD,       ma: MA_DT, mb: MB_RATE, br: BR_REQ};
         6'd1:  w = '{op: OP_RATE,       ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd2:  w = '{op: OP_MUL,        ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd3:  w = '{op: OP_ANGLE_PRED, ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd4:  w = '{op: OP_MUL,        ma: MA_DT, mb: MB_P11,  br: BR_NEXT};
         6'd5:  w = '{op: OP_DP11,       ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd6:  w = '{op: OP_T,          ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd7:  w = '{op: OP_MUL,        ma: MA_DT, mb: MB_T,    br: BR_NEXT};
         6'd8:  w = '{op: OP_P00_PRED,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd9:  w = '{op: OP_P01_PRED,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd10: w = '{op: OP_P10_PRED,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd11: w = '{op: OP_MUL,        ma: MA_DT, mb: MB_QB,   br: BR_NEXT};
         6'd12: w = '{op: OP_P11_PRED,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd13: w = '{op: OP_S,          ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd14: w = '{op: OP_Y,          ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd15: w = '{op: OP_DIV_K0,     ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd16: w = '{op: OP_NOP,        ma: MA_DT, mb: MB_RATE, br: BR_DIV};
         6'd17: w = '{op: OP_K0,         ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd18: w = '{op: OP_DIV_K1,     ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd19: w = '{op: OP_NOP,        ma: MA_DT, mb: MB_RATE, br: BR_DIV};
         6'd20: w = '{op: OP_K1,         ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd21: w = '{op: OP_MUL,        ma: MA_K0, mb: MB_Y,    br: BR_NEXT};
         6'd22: w = '{op: OP_ANGLE_CORR, ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd23: w = '{op: OP_MUL,        ma: MA_K1, mb: MB_Y,    br: BR_NEXT};
         6'd24: w = '{op: OP_BIAS_CORR,  ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd25: w = '{op: OP_MUL,        ma: MA_K1, mb: MB_P00,  br: BR_NEXT};
         6'd26: w = '{op: OP_P10_CORR,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd27: w = '{op: OP_MUL,        ma: MA_K0, mb: MB_P00,  br: BR_NEXT};
         6'd28: w = '{op: OP_P00_CORR,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd29: w = '{op: OP_MUL,        ma: MA_K1, mb: MB_P01,  br: BR_NEXT};
         6'd30: w = '{op: OP_P11_CORR,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd31: w = '{op: OP_MUL,        ma: MA_K0, mb: MB_P01,  br: BR_NEXT};
         6'd32: w = '{op: OP_P01_CORR,   ma: MA_DT, mb: MB_RATE, br: BR_NEXT};
         6'd33: w = '{op: OP_OUT,        ma: MA_DT, mb: MB_RATE, br: BR_END};
         default: w = '{op: OP_NOP,      ma: MA_DT, mb: MB_RATE, br: BR_HOME};
      endcase
      return w;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -68'sd2147483648) begin
         return -32'sh80000000;
      end
      return 32'(v);
   endfunction

   function automatic logic signed [39:0] sat40(input logic signed [67:0] v);
      if (v > 68'sd549755813887) begin
         return 40'sh7FFFFFFFFF;
      end else if (v < -68'sd549755813888) begin
         return -40'sh8000000000;
      end
      return 40'(v);
   endfunction

endpackage

`default_nettype wire

>>> sv/kalman_angle_bias_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-state angle and gyro-bias Kalman filter. Each request transaction carries a measured
// angle, a gyro rate and a time step; the block predicts, forms the innovation variance,
// derives two gains by division, corrects angle and bias, updates the 2x2 covariance and
// returns the corrected angle as one response transaction. A microprogram of 34 steps in a
// read-only table drives one shared 25 x 41 bit multiplier, an adder with saturation and a
// restoring divider that resolves one quotient bit per cycle; a gain division is bypassed
// when the gain saturates or the variance is zero. Items are handled one at a time: a new
// request is taken once the previous result has been placed in the response register,
// which may still be waiting to be taken. Noise settings must be written through the csr
// port only while no item is in flight; the block itself does not enforce this. An index
// beyond the third register is ignored.
module kalman_angle_bias_filter
   import kabf_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   // req_tdata: measured_angle [31:0], measured_rate [63:32], time_step [87:64]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [87:0] req_tdata,
   // rsp_tdata: angle_estimate [31:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [kabf_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire  [31:0] csr_data
);

   // Control state.
   logic [StepWidth-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 div_busy_ff, div_busy_in;

   // Settings and filter state.
   logic [NoiseWidth-1:0] qa_ff, qb_ff, r_ff;
   logic signed [AngleWidth-1:0] angle_ff, angle_in;
   logic signed [AngleWidth-1:0] bias_ff, bias_in;
   logic signed [CovWidth-1:0]   p_ff [4];
   logic signed [CovWidth-1:0]   p_in [4];

   // Working registers of one item.
   logic signed [AngleWidth-1:0] z_ff, z_in, w_ff, w_in, rate_ff, rate_in, y_ff, y_in;
   logic [DtWidth-1:0]           dt_ff, dt_in;
   logic signed [CovWidth:0]     dp11_ff, dp11_in, s_ff, s_in;
   logic signed [CovWidth-1:0]   t_ff, t_in;
   logic signed [GainWidth-1:0]  k0_ff, k0_in, k1_ff, k1_in;
   logic signed [65:0]           prod_ff, prod_in;
   logic [31:0]                  rsp_data_ff, rsp_data_in;

   // Divider registers.
   logic [41:0]                  rem_ff, rem_in, den_ff, den_in;
   logic [GainFrac-1:0]          quo_ff, quo_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic                         neg_ff, neg_in;
   logic signed [GainWidth-1:0]  q_ff, q_in;

   ctrl_type ctrl;
   logic     req_fire, slot_free, exec;
   logic signed [24:0] mul_a;
   logic signed [40:0] mul_b;
   logic signed [65:0] sh24, sh23;

   assign ctrl       = rom_word(step_ff);
   assign req_tready = (ctrl.br == BR_REQ);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A step with a wait condition only does its work on the cycle it is released.
   always_comb begin
      case (ctrl.br)
         BR_REQ:  exec = req_fire;
         BR_END:  exec = slot_free;
         default: exec = 1'b1;
      endcase
   end

   // Sequencer: next step.
   always_comb begin
      case (ctrl.br)
         BR_NEXT: step_in = step_ff + 1'b1;
         BR_REQ:  step_in = req_fire ? step_ff + 1'b1 : step_ff;
         BR_DIV:  step_in = div_busy_ff ? step_ff : step_ff + 1'b1;
         BR_END:  step_in = slot_free ? '0 : step_ff;
         default: step_in = '0;
      endcase
   end

   // Shared multiplier operands.
   always_comb begin
      case (ctrl.ma)
         MA_K0:   mul_a = 25'(k0_ff);
         MA_K1:   mul_a = 25'(k1_ff);
         default: mul_a = signed'({1'b0, dt_ff});
      endcase
      case (ctrl.mb)
         MB_RATE: mul_b = 41'(rate_ff);
         MB_P11:  mul_b = 41'(p_ff[P11]);
         MB_T:    mul_b = 41'(t_ff);
         MB_QB:   mul_b = signed'({9'd0, qb_ff});
         MB_Y:    mul_b = 41'(y_ff);
         MB_P00:  mul_b = 41'(p_ff[P00]);
         default: mul_b = 41'(p_ff[P01]);
      endcase
   end

   assign sh24 = prod_ff >>> DtFrac;
   assign sh23 = prod_ff >>> GainFrac;

   // Datapath: each op code updates its own destination.
   always_comb begin
      z_in = z_ff;  w_in = w_ff;  dt_in = dt_ff;
      rate_in = rate_ff;  y_in = y_ff;  dp11_in = dp11_ff;
      t_in = t_ff;  s_in = s_ff;  k0_in = k0_ff;  k1_in = k1_ff;
      angle_in = angle_ff;  bias_in = bias_ff;
      p_in = p_ff;
      prod_in = prod_ff;
      rsp_data_in = rsp_data_ff;
      if (exec) begin
         case (ctrl.op)
            OP_LOAD: begin
               z_in  = signed'(req_tdata[31:0]);
               w_in  = signed'(req_tdata[63:32]);
               dt_in = req_tdata[87:64];
            end
            OP_RATE:       rate_in = sat32(68'(w_ff) - 68'(bias_ff));
            OP_MUL:        prod_in = 66'(mul_a) * 66'(mul_b);
            OP_ANGLE_PRED: angle_in = sat32(68'(angle_ff) + 68'(sh24));
            OP_DP11:       dp11_in = 41'(sh24);
            OP_T: begin
               t_in = sat40(68'(dp11_ff) - 68'(p_ff[P01]) - 68'(p_ff[P10])
                            + signed'({36'd0, qa_ff}));
            end
            OP_P00_PRED:   p_in[P00] = sat40(68'(p_ff[P00]) + 68'(sh24));
            OP_P01_PRED:   p_in[P01] = sat40(68'(p_ff[P01]) - 68'(dp11_ff));
            OP_P10_PRED:   p_in[P10] = sat40(68'(p_ff[P10]) - 68'(dp11_ff));
            OP_P11_PRED:   p_in[P11] = sat40(68'(p_ff[P11]) + 68'(sh24));
            OP_S:          s_in = 41'(p_ff[P00]) + signed'({9'd0, r_ff});
            OP_Y:          y_in = sat32(68'(z_ff) - 68'(angle_ff));
            OP_K0:         k0_in = q_ff;
            OP_K1:         k1_in = q_ff;
            OP_ANGLE_CORR: angle_in = sat32(68'(angle_ff) + 68'(sh23));
            OP_BIAS_CORR:  bias_in = sat32(68'(bias_ff) + 68'(sh23));
            OP_P00_CORR:   p_in[P00] = sat40(68'(p_ff[P00]) - 68'(sh23));
            OP_P01_CORR:   p_in[P01] = sat40(68'(p_ff[P01]) - 68'(sh23));
            OP_P10_CORR:   p_in[P10] = sat40(68'(p_ff[P10]) - 68'(sh23));
            OP_P11_CORR:   p_in[P11] = sat40(68'(p_ff[P11]) - 68'(sh23));
            OP_OUT:        rsp_data_in = angle_ff;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (exec && ctrl.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Gain divider: signed fraction num / S, magnitude truncated, one bit per cycle.
   always_comb begin
      logic signed [41:0] num_x, den_x;
      logic [41:0]        nmag, dmag, r2;
      logic [GainFrac-1:0] qn;
      logic               ng;
      num_x = (ctrl.op == OP_DIV_K1) ? 42'(p_ff[P10]) : 42'(p_ff[P00]);
      den_x = 42'(s_ff);
      nmag  = num_x[41] ? unsigned'(-num_x) : unsigned'(num_x);
      dmag  = den_x[41] ? unsigned'(-den_x) : unsigned'(den_x);
      ng    = num_x[41] ^ den_x[41];
      r2    = {rem_ff[40:0], 1'b0};
      qn    = {quo_ff[GainFrac-2:0], (r2 >= den_ff)};
      rem_in = rem_ff;  den_in = den_ff;  quo_in = quo_ff;
      cnt_in = cnt_ff;  neg_in = neg_ff;  q_in = q_ff;
      div_busy_in = div_busy_ff;
      if (div_busy_ff) begin
         rem_in = (r2 >= den_ff) ? r2 - den_ff : r2;
         quo_in = qn;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            div_busy_in = 1'b0;
            q_in = neg_ff ? -signed'({1'b0, qn}) : signed'({1'b0, qn});
         end
      end else if (ctrl.op == OP_DIV_K0 || ctrl.op == OP_DIV_K1) begin
         neg_in = ng;
         if (s_ff == '0) begin
            q_in = '0;
         end else if (nmag >= dmag) begin
            q_in = ng ? GAIN_MIN : GAIN_MAX;
         end else begin
            rem_in = nmag;
            den_in = dmag;
            quo_in = '0;
            cnt_in = 5'(GainFrac - 1);
            div_busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_busy_ff  <= 1'b0;
         qa_ff        <= QA_RESET;
         qb_ff        <= QB_RESET;
         r_ff         <= R_RESET;
         angle_ff     <= '0;
         bias_ff      <= '0;
         p_ff         <= '{default: '0};
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         div_busy_ff  <= div_busy_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         p_ff         <= p_in;
         if (csr_valid) begin
            case (csr_index)
               REG_QA:  qa_ff <= csr_data;
               REG_QB:  qb_ff <= csr_data;
               REG_R:   r_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;  w_ff <= w_in;  dt_ff <= dt_in;
      rate_ff <= rate_in;  y_ff <= y_in;  dp11_ff <= dp11_in;
      t_ff <= t_in;  s_ff <= s_in;  k0_ff <= k0_in;  k1_ff <= k1_in;
      prod_ff <= prod_in;
      rsp_data_ff <= rsp_data_in;
      rem_ff <= rem_in;  den_ff <= den_in;  quo_ff <= quo_in;
      cnt_ff <= cnt_in;  neg_ff <= neg_in;  q_ff <= q_in;
   end

endmodule

`default_nettype wire

>>> sv/kabf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kabf_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        csr_valid,
   input wire        csr_ready
);

   // Items are processed one at a time, so an accepted transaction closes the input.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item was in flight");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready)
      else $error("block not ready after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the angle and gyro-bias Kalman filter. A directed table of
// transactions is sent first, then random sequences of sensor samples. Every request
// is fed to a behavioural copy of the filter, and its estimate, or a typed-in one, is queued.
// Each response transaction is checked against the oldest queued estimate.
module tb;
   import kabf_pkg::*;

   localparam longint Max32 = 64'sd2147483647;
   localparam longint Min32 = -64'sd2147483648;
   localparam longint Max40 = 64'sd549755813887;
   localparam longint Min40 = -64'sd549755813888;
   localparam int CycleLimit = 2000000;
   localparam int RandomItems = 1830;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   kalman_angle_bias_filter u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The filter state as the predictor holds it.
   logic [31:0] noise_qa, noise_qb, noise_r;
   longint      est_angle, est_bias;
   longint      est_cov [4];

   logic [31:0] angle_expected [$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          hold_off = 1'b0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Arithmetic shift of a signed 64-bit value is a floor shift.
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint gain_quotient(longint num, longint den);
      longint unsigned n, d, q, r;
      bit neg;
      if (den == 0) return 0;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      if (n >= d) return neg ? -64'sd8388608 : 64'sd8388607;
      r = n;
      q = 0;
      for (int i = 0; i < GainFrac; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 1;
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic void filter_reset();
      noise_qa = QA_RESET;
      noise_qb = QB_RESET;
      noise_r = R_RESET;
      est_angle = 0;
      est_bias = 0;
      foreach (est_cov[i]) est_cov[i] = 0;
   endfunction

   // Runs one sample through the predictor and returns the corrected angle.
   function automatic logic [31:0] filter_sample(logic [87:0] d);
      longint z, w, dt, p00, p01, p10, p11, rate, dp11, t, s, k0, k1, y;
      z = longint'($signed(d[31:0]));
      w = longint'($signed(d[63:32]));
      dt = longint'(d[87:64]);
      p00 = est_cov[0];
      p01 = est_cov[1];
      p10 = est_cov[2];
      p11 = est_cov[3];
      rate = clamp(w - est_bias, Min32, Max32);
      est_angle = clamp(est_angle + shr_floor(dt * rate, DtFrac), Min32, Max32);
      dp11 = shr_floor(dt * p11, DtFrac);
      t = clamp(dp11 - p01 - p10 + longint'(noise_qa), Min40, Max40);
      p00 = clamp(p00 + shr_floor(dt * t, DtFrac), Min40, Max40);
      p01 = clamp(p01 - dp11, Min40, Max40);
      p10 = clamp(p10 - dp11, Min40, Max40);
      p11 = clamp(p11 + ((longint'(noise_qb) * dt) >>> DtFrac), Min40, Max40);
      s = p00 + longint'(noise_r);
      k0 = gain_quotient(p00, s);
      k1 = gain_quotient(p10, s);
      y = clamp(z - est_angle, Min32, Max32);
      est_angle = clamp(est_angle + shr_floor(k0 * y, GainFrac), Min32, Max32);
      est_bias = clamp(est_bias + shr_floor(k1 * y, GainFrac), Min32, Max32);
      // The covariance update uses the predicted P00 and P01.
      est_cov[0] = clamp(p00 - shr_floor(k0 * p00, GainFrac), Min40, Max40);
      est_cov[1] = clamp(p01 - shr_floor(k0 * p01, GainFrac), Min40, Max40);
      est_cov[2] = clamp(p10 - shr_floor(k1 * p00, GainFrac), Min40, Max40);
      est_cov[3] = clamp(p11 - shr_floor(k1 * p01, GainFrac), Min40, Max40);
      return est_angle[31:0];
   endfunction

   // Directed rows: angle, rate, time step, and a typed-in estimate where it is obvious.
   typedef struct {
      logic [31:0] angle;
      logic [31:0] rate;
      logic [23:0] dt;
      bit          known;
      logic [31:0] estimate;
   } sample_row_type;

   sample_row_type directed_rows [] = '{
      // Straight after reset with a zero step the covariance is tiny, so the gain is nil.
      '{32'h0000_0000, 32'h0000_0000, 24'h000000, 1'b1, 32'h0000_0000},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b0, 32'h0},
      '{32'h8000_0000, 32'h8000_0000, 24'hFFFFFF, 1'b0, 32'h0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 24'h000001, 1'b0, 32'h0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 24'h800000, 1'b0, 32'h0},
      '{32'h0001_0000, 32'h0000_0000, 24'h010000, 1'b0, 32'h0},
      '{32'hFFFF_0000, 32'h0002_0000, 24'h004000, 1'b0, 32'h0},
      '{32'h0000_0000, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b0, 32'h0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 24'h555555, 1'b0, 32'h0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 24'hAAAAAA, 1'b0, 32'h0},
      '{32'h0000_0001, 32'h0000_0001, 24'h000000, 1'b0, 32'h0},
      '{32'h1234_5678, 32'hFEDC_BA98, 24'h123456, 1'b0, 32'h0}
   };

   logic [87:0] stim_item [$];
   bit          stim_known [$];
   logic [31:0] stim_value [$];

   // One write transaction; the task returns with valid low and the channel idle.
   task automatic write_register(logic [CsrIdxWidth-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_QA: noise_qa = value;
         REG_QB: noise_qb = value;
         REG_R:  noise_r = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Waits until every expected estimate has come, then lets the divider run dry.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (angle_expected.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // With no gap the next request is offered straight away; otherwise valid drops
   // for the drawn number of cycles.
   task automatic send_sample(logic [87:0] d, bit known, logic [31:0] value);
      logic [31:0] predicted;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = filter_sample(d);
      angle_expected.push_back(known ? value : predicted);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_word(int spread);
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2 * (spread >> 4))) - (spread >> 4));
      endcase
   endfunction

   // Random noise settings, often small so that gains stay in range, sometimes extreme.
   task automatic random_settings();
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(0, 3))
            0: write_register(CsrIdxWidth'(i), $urandom());
            1: write_register(CsrIdxWidth'(i), $urandom_range(1, 1 << 26));
            2: write_register(CsrIdxWidth'(i), i == REG_R ? 32'd1 : 32'd0);
            default: write_register(CsrIdxWidth'(i), 32'hFFFF_FFFF);
         endcase
      end
   endtask

   // Response side: random stall per transaction, with a long hold-off when asked.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         if (stall != 0 || hold_off) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
            while (hold_off) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (angle_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected angle estimate %h", rsp_tdata);
         end else begin
            if (rsp_tdata !== angle_expected[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("angle estimate mismatch: expected %h, got %h",
                     angle_expected[0], rsp_tdata);
            end
            void'(angle_expected.pop_front());
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int phase_len;
      logic [31:0] z;
      filter_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample({directed_rows[i].dt, directed_rows[i].rate, directed_rows[i].angle},
            directed_rows[i].known, directed_rows[i].estimate);
      drain();

      // Measurement noise at its floor lets the variance reach zero with a negative P00.
      write_register(REG_QA, 32'd0);
      write_register(REG_QB, 32'hFFFF_FFFF);
      write_register(REG_R, 32'd1);
      write_register(2'd3, 32'hDEAD_BEEF);
      for (int i = 0; i < 10; i++)
         send_sample({24'hFFFFFF, random_word(1 << 20), random_word(1 << 24)}, 1'b0, 32'h0);
      drain();

      // Long hold-off on the response side while requests keep coming.
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 8; i++)
            send_sample({24'($urandom()), $urandom(), $urandom()}, 1'b0, 32'h0);
      join
      drain();

      for (int sent = 0; sent < RandomItems; sent += phase_len) begin
         if ($urandom_range(0, 2) == 0) random_settings();
         else begin
            write_register(REG_QA, QA_RESET);
            write_register(REG_QB, QB_RESET);
            write_register(REG_R, R_RESET);
         end
         phase_len = $urandom_range(20, 120);
         if (phase_len > RandomItems - sent) phase_len = RandomItems - sent;
         // Mostly a steady sensor track with a slowly drifting angle; some raw noise.
         z = $urandom();
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 9) < 7) begin
               z = z + 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
               send_sample({24'($urandom_range(0, 1 << 16)), random_word(1 << 22), z},
                  1'b0, 32'h0);
            end else
               send_sample({24'($urandom()), $urandom(), $urandom()}, 1'b0, 32'h0);
         end
         drain();
      end

      drain();
      if (mismatches == 0 && angle_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> kalman_angle_bias_filter.f
sv/kabf_pkg.sv
sv/kalman_angle_bias_filter.sv
sv/kabf_checker.sv
tb/tb.sv
